// ===== rtl/core/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc_pkg: shared definitions for the cluster chain engine
// Field widths, FAT32 link constants, mode/status/register codes, FSM states.
// ----------------------------------------------------------------------------
package fcc_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;

  localparam int ENTRY_W = 32;
  localparam int LINK_W  = 28;
  localparam int KEEP_W  = ENTRY_W - LINK_W;
  localparam int HINT_W  = 13;
  localparam int LEN_W   = 13;
  localparam int STAT_W  = 2;
  localparam int MODE_W  = 3;
  localparam int CFG_W   = 28;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 88;

  localparam logic [LINK_W-1:0] END_FIRST      = 28'hFFFFFF8;
  localparam logic [LINK_W-1:0] END_MARKER_RST = 28'hFFFFFFF;
  localparam logic [HINT_W-1:0] ENTRIES_RST    = 13'd4096;
  localparam logic [LEN_W-1:0]  LEN_MAX        = 13'h1FFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_GET   = 3'd0,
    MODE_SET   = 3'd1,
    MODE_ALLOC = 3'd2,
    MODE_FREE  = 3'd3,
    MODE_TRUNC = 3'd4,
    MODE_COUNT = 3'd5,
    MODE_RAW   = 3'd6,
    MODE_LOAD  = 3'd7
  } fcc_mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_LOOP    = 2'd3
  } fcc_status_t;

  typedef enum logic [0:0] {
    CFG_ENTRIES    = 1'b0,
    CFG_END_MARKER = 1'b1
  } fcc_cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GET,
    ST_SET,
    ST_SCAN,
    ST_ALINK,
    ST_WALK,
    ST_TRUNC,
    ST_TEND,
    ST_COUNT,
    ST_HOLD
  } fcc_state_t;

  // chain length saturates at the field maximum
  function automatic logic [LEN_W-1:0] len_sat(input logic [31:0] n);
    logic [LEN_W-1:0] r;
    if (n > 32'(LEN_MAX)) r = LEN_MAX;
    else r = n[LEN_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/fcc_ram.sv =====
// ----------------------------------------------------------------------------
// fcc_ram: generic single-write, single-read synchronous RAM
// Registered read; read during write returns old data.
// ----------------------------------------------------------------------------
module fcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fat_cluster_chain_engine_top.sv =====
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_top: FAT32 allocation table engine
// Allocate scans entries from the hint (then links the previous cluster when
// asked); free and truncate walk the chain, count reads it entry by entry.
// One transaction at a time; each step costs one read of the table memory port.
// Reset (rst_n, synchronous) clears control, hint and free count and sets the
// entry count and end marker to their defaults; the table is not cleared and
// holds garbage until loaded.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine_top #(
  parameter int TABLE_DEPTH = fcc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config write port
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [fcc_pkg::CFG_W-1:0]        cfg_wdata,
  // request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [27:0] cluster, [59:28] value, [60] link_previous, [73:61] hint_value
  input  logic [fcc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [2:0] mode
  input  logic [fcc_pkg::MODE_W-1:0]       in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [27:0] cluster_out, [40:28] chain_length, [72:41] free_total,
  // [85:73] hint_out
  output logic [fcc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [fcc_pkg::STAT_W-1:0]       out_tuser
);
  import fcc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = (AW + 1 > HINT_W) ? AW + 1 : HINT_W;
  localparam logic [CW-1:0]     TD_C    = CW'(TABLE_DEPTH);
  localparam logic [LINK_W-1:0] TD_LINK = LINK_W'(TABLE_DEPTH);

  // input unpack
  fcc_mode_t          in_mode;
  logic [LINK_W-1:0]  in_cl;
  logic [ENTRY_W-1:0] in_val;
  logic               in_linkp;
  logic [HINT_W-1:0]  in_hv;
  logic               in_fire;
  logic               in_range;

  assign in_mode  = fcc_mode_t'(in_tuser);
  assign in_cl    = in_tdata[27:0];
  assign in_val   = in_tdata[59:28];
  assign in_linkp = in_tdata[60];
  assign in_hv    = in_tdata[73:61];
  assign in_fire  = in_tvalid && in_tready;
  assign in_range = in_cl < TD_LINK;

  // state
  fcc_state_t         state_r, state_nxt;
  fcc_mode_t          mode_r, mode_nxt;
  logic [AW-1:0]      cl_r, cl_nxt;
  logic [LINK_W-1:0]  val_r, val_nxt;
  logic               linkp_r, linkp_nxt;
  logic [AW-1:0]      cur_r, cur_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      scan_r, scan_nxt;
  logic [KEEP_W-1:0]  upper_r, upper_nxt;
  fcc_status_t        res_status_r, res_status_nxt;
  logic [LINK_W-1:0]  res_cout_r, res_cout_nxt;
  logic [LEN_W-1:0]   res_len_r, res_len_nxt;
  logic [HINT_W-1:0]  hint_r, hint_nxt;
  logic [ENTRY_W-1:0] free_r, free_nxt;
  logic [HINT_W-1:0]  entries_r, entries_nxt;
  logic [LINK_W-1:0]  endm_r, endm_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_user_r, out_user_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // memory port
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] ram_q;
  logic               fwd_hit_r;
  logic [ENTRY_W-1:0] fwd_data_r;
  logic [ENTRY_W-1:0] q;
  logic [LINK_W-1:0]  q_link;
  logic               q_end;
  logic               q_oor;

  fcc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (ram_q)
  );

  // a read issued together with a write to the same entry must see the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= mem_we && (mem_waddr == mem_raddr);
    end
    fwd_data_r <= mem_wdata;
  end

  assign q      = fwd_hit_r ? fwd_data_r : ram_q;
  assign q_link = q[LINK_W-1:0];
  assign q_end  = (q_link == '0) || (q_link >= END_FIRST);
  assign q_oor  = q_link >= TD_LINK;

  logic [CW-1:0]     limit;
  logic [CW-1:0]     scan_inc;
  logic [CW-1:0]     cnt_inc;
  logic              out_free;
  logic              fin;
  fcc_status_t       fin_status;
  logic [LINK_W-1:0] fin_cout;
  logic [LEN_W-1:0]  fin_len;
  logic              walk_done;
  fcc_status_t       walk_status;

  assign limit    = (CW'(entries_r) < TD_C) ? CW'(entries_r) : TD_C;
  assign scan_inc = scan_r + CW'(1);
  assign cnt_inc  = cnt_r + CW'(1);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    cl_nxt         = cl_r;
    val_nxt        = val_r;
    linkp_nxt      = linkp_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    upper_nxt      = upper_r;
    res_status_nxt = res_status_r;
    res_cout_nxt   = res_cout_r;
    res_len_nxt    = res_len_r;
    hint_nxt       = hint_r;
    free_nxt       = free_r;
    entries_nxt    = entries_r;
    endm_nxt       = endm_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_user_nxt   = out_user_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = cur_r;
    mem_wdata      = '0;
    mem_raddr      = cur_r;
    fin            = 1'b0;
    fin_status     = STAT_OK;
    fin_cout       = '0;
    fin_len        = '0;
    walk_done      = 1'b0;
    walk_status    = STAT_OK;

    if (cfg_we) begin
      unique case (fcc_cfg_reg_t'(cfg_index))
        CFG_ENTRIES:    entries_nxt = cfg_wdata[HINT_W-1:0];
        CFG_END_MARKER: endm_nxt    = cfg_wdata;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt  = in_mode;
          cl_nxt    = AW'(in_cl);
          val_nxt   = in_val[LINK_W-1:0];
          linkp_nxt = in_linkp;
          mem_raddr = AW'(in_cl);
          unique case (in_mode)
            MODE_GET: begin
              if (!in_range) begin
                fin = 1'b1; fin_status = STAT_RANGE;
              end else begin
                state_nxt = ST_GET;
              end
            end
            MODE_SET: begin
              if (!in_range) begin
                fin = 1'b1; fin_status = STAT_RANGE;
              end else begin
                state_nxt = ST_SET;
              end
            end
            MODE_ALLOC: begin
              if (in_linkp && !in_range) begin
                fin = 1'b1; fin_status = STAT_RANGE;
              end else if (CW'(hint_r) >= limit) begin
                fin = 1'b1; fin_status = STAT_NO_FREE;
              end else begin
                mem_raddr = AW'(hint_r);
                scan_nxt  = CW'(hint_r);
                state_nxt = ST_SCAN;
              end
            end
            MODE_FREE: begin
              if (!in_range) begin
                fin = 1'b1; fin_status = STAT_RANGE;
              end else if (in_cl == '0) begin
                fin = 1'b1;
              end else begin
                cur_nxt   = AW'(in_cl);
                cnt_nxt   = '0;
                state_nxt = ST_WALK;
              end
            end
            MODE_TRUNC: begin
              if (!in_range) begin
                fin = 1'b1; fin_status = STAT_RANGE;
              end else begin
                state_nxt = ST_TRUNC;
              end
            end
            MODE_COUNT: begin
              if ((in_cl == '0) || (in_cl >= END_FIRST)) begin
                fin = 1'b1;
              end else if (!in_range) begin
                fin = 1'b1; fin_status = STAT_RANGE;
              end else begin
                cnt_nxt   = '0;
                state_nxt = ST_COUNT;
              end
            end
            MODE_RAW: begin
              if (!in_range) begin
                fin = 1'b1; fin_status = STAT_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_cl);
                mem_wdata = in_val;
                fin       = 1'b1;
              end
            end
            MODE_LOAD: begin
              hint_nxt = in_hv;
              free_nxt = in_val;
              fin      = 1'b1;
            end
          endcase
        end
      end

      ST_GET: begin
        fin      = 1'b1;
        fin_cout = q_link;
      end

      ST_SET: begin
        mem_we    = 1'b1;
        mem_waddr = cl_r;
        mem_wdata = {q[ENTRY_W-1:LINK_W], val_r};
        fin       = 1'b1;
      end

      ST_SCAN: begin
        if (q_link == '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(scan_r);
          mem_wdata = {q[ENTRY_W-1:LINK_W], endm_r};
          hint_nxt  = HINT_W'(scan_r);
          free_nxt  = free_r - ENTRY_W'(1);
          if (linkp_r) begin
            mem_raddr = cl_r;
            state_nxt = ST_ALINK;
          end else begin
            fin      = 1'b1;
            fin_cout = LINK_W'(scan_r);
          end
        end else if (scan_inc >= limit) begin
          fin        = 1'b1;
          fin_status = STAT_NO_FREE;
        end else begin
          scan_nxt  = scan_inc;
          mem_raddr = AW'(scan_inc);
        end
      end

      ST_ALINK: begin
        mem_we    = 1'b1;
        mem_waddr = cl_r;
        mem_wdata = {q[ENTRY_W-1:LINK_W], LINK_W'(scan_r)};
        fin       = 1'b1;
        fin_cout  = LINK_W'(scan_r);
      end

      ST_WALK: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = {q[ENTRY_W-1:LINK_W], {LINK_W{1'b0}}};
        free_nxt  = free_r + ENTRY_W'(1);
        priority if (q_end) begin
          walk_done = 1'b1;
        end else if (q_oor) begin
          walk_done = 1'b1; walk_status = STAT_RANGE;
        end else if (cnt_inc >= TD_C) begin
          walk_done = 1'b1; walk_status = STAT_LOOP;
        end else begin
          cnt_nxt   = cnt_inc;
          cur_nxt   = AW'(q_link);
          mem_raddr = AW'(q_link);
        end
        if (walk_done) begin
          if (mode_r == MODE_TRUNC) begin
            res_status_nxt = walk_status;
            state_nxt      = ST_TEND;
          end else begin
            fin        = 1'b1;
            fin_status = walk_status;
          end
        end
      end

      ST_TRUNC: begin
        if (q_end) begin
          fin = 1'b1;
        end else begin
          upper_nxt = q[ENTRY_W-1:LINK_W];
          if (q_oor) begin
            mem_we     = 1'b1;
            mem_waddr  = cl_r;
            mem_wdata  = {q[ENTRY_W-1:LINK_W], endm_r};
            fin        = 1'b1;
            fin_status = STAT_RANGE;
          end else begin
            cur_nxt   = AW'(q_link);
            mem_raddr = AW'(q_link);
            cnt_nxt   = '0;
            state_nxt = ST_WALK;
          end
        end
      end

      // end marker goes in last: the walk may pass through the truncated entry
      ST_TEND: begin
        mem_we     = 1'b1;
        mem_waddr  = cl_r;
        mem_wdata  = {upper_r, endm_r};
        fin        = 1'b1;
        fin_status = res_status_r;
      end

      ST_COUNT: begin
        priority if (q_end) begin
          fin = 1'b1;
        end else if (q_oor) begin
          fin = 1'b1; fin_status = STAT_RANGE;
        end else if (cnt_inc >= TD_C) begin
          fin = 1'b1; fin_status = STAT_LOOP;
        end else begin
          cnt_nxt   = cnt_inc;
          mem_raddr = AW'(q_link);
        end
        fin_len = len_sat(32'(cnt_inc));
      end

      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_status_r;
          out_data_nxt  = {2'b00, hint_r, free_r, res_len_r, res_cout_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_user_nxt  = fin_status;
        out_data_nxt  = {2'b00, hint_nxt, free_nxt, fin_len, fin_cout};
        state_nxt     = ST_IDLE;
      end else begin
        res_status_nxt = fin_status;
        res_cout_nxt   = fin_cout;
        res_len_nxt    = fin_len;
        state_nxt      = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hint_r      <= '0;
      free_r      <= '0;
      entries_r   <= ENTRIES_RST;
      endm_r      <= END_MARKER_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hint_r      <= hint_nxt;
      free_r      <= free_nxt;
      entries_r   <= entries_nxt;
      endm_r      <= endm_nxt;
    end
    mode_r       <= mode_nxt;
    cl_r         <= cl_nxt;
    val_r        <= val_nxt;
    linkp_r      <= linkp_nxt;
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    scan_r       <= scan_nxt;
    upper_r      <= upper_nxt;
    res_status_r <= res_status_nxt;
    res_cout_r   <= res_cout_nxt;
    res_len_r    <= res_len_nxt;
    out_user_r   <= out_user_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  // every accepted transaction leaves idle or produces a result
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE) || out_tvalid)
    else $error("accepted transaction made no progress");

  // free count moves only on scan, walk or a counter load
  a_free_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !((state_r == ST_SCAN) || (state_r == ST_WALK) || in_fire) |=> $stable(free_r))
    else $error("free count changed outside allocate/free");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WALK) || (state_r == ST_COUNT)) |-> (cnt_r < TD_C))
    else $error("chain walk ran past table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_r < limit))
    else $error("allocation scan past limit");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_tvalid)
    else $error("result held while output register empty");

endmodule

// ===== tb/fat_chain_checker.sv =====
// ----------------------------------------------------------------------------
// fat_chain_checker: result predictor and scoreboard for the chain engine
// Watches the config port and both streams, keeps its own copy of the
// allocation table, hint and free count, predicts one result per request
// and compares every returned result field by field, oldest first.
// ----------------------------------------------------------------------------
module fat_chain_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [fcc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [27:0] cluster, [59:28] value, [60] link_previous, [73:61] hint_value
  input  logic [fcc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] mode
  input  logic [fcc_pkg::MODE_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [27:0] cluster_out, [40:28] chain_length, [72:41] free_total,
  // [85:73] hint_out
  input  logic [fcc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  input  logic [fcc_pkg::STAT_W-1:0]      out_tuser,
  output int                              mismatches,
  output int                              pending,
  output int                              checked,
  output int                              flagged
);
  import fcc_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  // output field offsets
  localparam int LEN_LSB  = LINK_W;
  localparam int FREE_LSB = LINK_W + LEN_W;
  localparam int HINT_LSB = LINK_W + LEN_W + 32;

  typedef struct packed {
    fcc_status_t         status;
    logic [LINK_W-1:0]   link;
    logic [LEN_W-1:0]    length;
    logic [31:0]         free_cnt;
    logic [HINT_W-1:0]   hint;
  } chain_result_t;

  logic [ENTRY_W-1:0] fat [DEPTH];
  logic [HINT_W-1:0]  next_hint;
  logic [31:0]        free_cnt;
  logic [HINT_W-1:0]  scan_entries;
  logic [LINK_W-1:0]  eoc_value;
  chain_result_t      expected_results [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
    flagged    = 0;
  end

  // link writes keep the top nibble of the entry
  function automatic void put_link(input int idx, input logic [LINK_W-1:0] link);
    fat[idx] = {fat[idx][ENTRY_W-1:LINK_W], link};
  endfunction

  function automatic fcc_status_t free_chain(input logic [LINK_W-1:0] start);
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nxt;
    int steps;
    cur = start;
    for (steps = 0; steps < DEPTH; steps++) begin
      nxt = fat[cur][LINK_W-1:0];
      put_link(int'(cur), '0);
      free_cnt = free_cnt + 32'd1;
      if (nxt == '0 || nxt >= END_FIRST) return STAT_OK;
      if (nxt >= DEPTH) return STAT_RANGE;
      cur = nxt;
    end
    return STAT_LOOP;
  endfunction

  function automatic chain_result_t resolve_request(input fcc_mode_t mode,
                                                    input logic [LINK_W-1:0] cl,
                                                    input logic [31:0] val,
                                                    input logic linkp,
                                                    input logic [HINT_W-1:0] hv);
    chain_result_t r;
    logic in_range;
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] c;
    int limit;
    int i;
    int n;
    r.status = STAT_OK;
    r.link   = '0;
    r.length = '0;
    in_range = (cl < DEPTH);
    case (mode)
      MODE_GET: begin
        if (!in_range) r.status = STAT_RANGE;
        else r.link = fat[cl][LINK_W-1:0];
      end
      MODE_SET: begin
        if (!in_range) r.status = STAT_RANGE;
        else put_link(int'(cl), val[LINK_W-1:0]);
      end
      MODE_ALLOC: begin
        limit = (scan_entries < DEPTH) ? int'(scan_entries) : DEPTH;
        if (linkp && !in_range) begin
          r.status = STAT_RANGE;
        end else begin
          r.status = STAT_NO_FREE;
          for (i = int'(next_hint); i < limit; i++) begin
            if (fat[i][LINK_W-1:0] == '0) begin
              put_link(i, eoc_value);
              next_hint = HINT_W'(i);
              free_cnt  = free_cnt - 32'd1;
              if (linkp) put_link(int'(cl), LINK_W'(i));
              r.link   = LINK_W'(i);
              r.status = STAT_OK;
              break;
            end
          end
        end
      end
      MODE_FREE: begin
        if (!in_range) r.status = STAT_RANGE;
        else if (cl != '0) r.status = free_chain(cl);
      end
      MODE_TRUNC: begin
        if (!in_range) begin
          r.status = STAT_RANGE;
        end else begin
          nxt = fat[cl][LINK_W-1:0];
          // nothing to cut when the cluster already ends its chain
          if (!(nxt == '0 || nxt >= END_FIRST)) begin
            if (nxt >= DEPTH) r.status = STAT_RANGE;
            else r.status = free_chain(nxt);
            put_link(int'(cl), eoc_value);
          end
        end
      end
      MODE_COUNT: begin
        c = cl;
        n = 0;
        while (c != '0 && c < END_FIRST) begin
          if (c >= DEPTH) begin
            r.status = STAT_RANGE;
            break;
          end
          if (n >= DEPTH) begin
            r.status = STAT_LOOP;
            break;
          end
          c = fat[c][LINK_W-1:0];
          n++;
        end
        r.length = (n > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(n);
      end
      MODE_RAW: begin
        if (!in_range) r.status = STAT_RANGE;
        else fat[cl] = val;
      end
      default: begin
        next_hint = hv;
        free_cnt  = val;
      end
    endcase
    r.free_cnt = free_cnt;
    r.hint     = next_hint;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch %0d: %s at result %0d, got 0x%0h want 0x%0h",
             mismatches, what, checked, got, want);
  endtask

  task automatic check_result();
    chain_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no request outstanding", 32'(out_tuser), '0);
      return;
    end
    want = expected_results.pop_front();
    checked++;
    if (want.status != STAT_OK) flagged++;
    if (out_tuser != want.status)
      report_mismatch("status", 32'(out_tuser), 32'(want.status));
    if (out_tdata[LINK_W-1:0] != want.link)
      report_mismatch("cluster_out", 32'(out_tdata[LINK_W-1:0]), 32'(want.link));
    if (out_tdata[LEN_LSB +: LEN_W] != want.length)
      report_mismatch("chain_length", 32'(out_tdata[LEN_LSB +: LEN_W]),
                      32'(want.length));
    if (out_tdata[FREE_LSB +: 32] != want.free_cnt)
      report_mismatch("free_total", out_tdata[FREE_LSB +: 32], want.free_cnt);
    if (out_tdata[HINT_LSB +: HINT_W] != want.hint)
      report_mismatch("hint_out", 32'(out_tdata[HINT_LSB +: HINT_W]),
                      32'(want.hint));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      next_hint    = '0;
      free_cnt     = '0;
      scan_entries = ENTRIES_RST;
      eoc_value    = END_MARKER_RST;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (fcc_cfg_reg_t'(cfg_index))
          CFG_ENTRIES: scan_entries = cfg_wdata[HINT_W-1:0];
          default:     eoc_value    = cfg_wdata[LINK_W-1:0];
        endcase
      end
      // results of a request accepted at this edge cannot leave at this edge
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready)
        expected_results.push_back(resolve_request(fcc_mode_t'(in_tuser),
                                                   in_tdata[LINK_W-1:0],
                                                   in_tdata[LINK_W +: 32],
                                                   in_tdata[LINK_W + 32],
                                                   in_tdata[LINK_W + 33 +: HINT_W]));
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the cluster chain engine
// Preloads the low part of the table, runs directed corner requests, then
// random chain building and chain operations mixed with noise under several
// register settings, with random stalls on both streams. Checking lives in
// the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import fcc_pkg::*;

  localparam int DEPTH         = TABLE_DEPTH_DEF;
  // entries loaded up front; chains stay in the lower half, so the upper
  // half always holds free entries and scans never leave the loaded region
  localparam int PRELOAD       = 512;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int PHASES        = 6;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 20;
  // longest quiet stretch: a full-depth walk plus a long receiver hold
  localparam int STALL_LIMIT   = 4 * (DEPTH + HOLD_CYCLES + 32);

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  // [27:0] cluster, [59:28] value, [60] link_previous, [73:61] hint_value
  logic [IN_TDATA_W-1:0]  in_tdata;
  // [2:0] mode
  logic [MODE_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // [27:0] cluster_out, [40:28] chain_length, [72:41] free_total, [85:73] hint_out
  logic [OUT_TDATA_W-1:0] out_tdata;
  // [1:0] status
  logic [STAT_W-1:0]      out_tuser;

  int mismatches;
  int pending;
  int checked;
  int flagged;

  bit quiet;
  int hold_asked;
  int sent;

  always #1 clk = ~clk;

  fat_cluster_chain_engine_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  fat_chain_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .flagged    (flagged)
  );

  // one request transaction; returns at the falling edge after acceptance
  task automatic send_req(input fcc_mode_t mode, input logic [LINK_W-1:0] cluster,
                          input logic [31:0] value, input logic linkp,
                          input logic [HINT_W-1:0] hint);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {6'b0, hint, linkp, value, cluster};
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input fcc_cfg_reg_t idx, input logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // a small neighborhood so chains, allocations and frees collide
  function automatic int pick_index();
    return int'($urandom_range(0, PRELOAD / 2 - 1));
  endfunction

  // build a short chain (its tail is an end marker, a free link or an out-of-range link), then operate on it
  task automatic run_chain_sequence();
    int nodes [$];
    int len;
    int k;
    bit use_raw;
    logic [31:0] v;
    if ($urandom_range(0, 7) == 0)
      send_req(MODE_LOAD, LINK_W'($urandom()), $urandom(), 1'b0,
               HINT_W'($urandom_range(0, 63)));
    len = $urandom_range(1, 5);
    for (k = 0; k < len; k++) nodes.push_back(pick_index());
    use_raw = ($urandom_range(0, 2) == 0);
    for (k = 0; k < len; k++) begin
      v = $urandom();
      if (k < len - 1) begin
        v[LINK_W-1:0] = LINK_W'(nodes[k + 1]);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: v[LINK_W-1:0] = END_FIRST + LINK_W'($urandom_range(0, 7));
          6, 7:             v[LINK_W-1:0] = '0;
          default:          v[LINK_W-1:0] = LINK_W'($urandom_range(DEPTH, 32'h0FFF_FFF7));
        endcase
      end
      send_req(use_raw ? MODE_RAW : MODE_SET, LINK_W'(nodes[k]), v,
               1'($urandom_range(0, 1)), HINT_W'($urandom()));
    end
    case ($urandom_range(0, 5))
      0: send_req(MODE_COUNT, LINK_W'(nodes[0]), $urandom(), 1'b0, HINT_W'($urandom()));
      1: begin
        send_req(MODE_TRUNC, LINK_W'(nodes[$urandom_range(0, len - 1)]), $urandom(),
                 1'b1, HINT_W'($urandom()));
        send_req(MODE_COUNT, LINK_W'(nodes[0]), $urandom(), 1'b0, HINT_W'($urandom()));
      end
      2: send_req(MODE_FREE, LINK_W'(nodes[0]), $urandom(), 1'b0, HINT_W'($urandom()));
      3: send_req(MODE_GET, LINK_W'(nodes[$urandom_range(0, len - 1)]), $urandom(), 1'b1,
                  HINT_W'($urandom()));
      4: begin
        // append a fresh cluster to the tail
        send_req(MODE_ALLOC, LINK_W'(nodes[len - 1]), $urandom(), 1'b1,
                 HINT_W'($urandom()));
        send_req(MODE_COUNT, LINK_W'(nodes[0]), $urandom(), 1'b0, HINT_W'($urandom()));
      end
      default: begin
        send_req(MODE_ALLOC, LINK_W'(pick_index()), $urandom(), 1'b0,
                 HINT_W'($urandom()));
        send_req(MODE_FREE, LINK_W'(nodes[0]), $urandom(), 1'b1, HINT_W'($urandom()));
      end
    endcase
  endtask

  task automatic send_noise_item();
    fcc_mode_t mode;
    logic [LINK_W-1:0] cl;
    logic [31:0] v;
    logic [HINT_W-1:0] h;
    mode = fcc_mode_t'($urandom_range(0, 7));
    cl   = ($urandom_range(0, 7) == 0) ? LINK_W'($urandom_range(DEPTH, 32'h0FFF_FFFF))
                                       : LINK_W'(pick_index());
    v    = $urandom();
    // keep links out of the unloaded part of the table
    if ((v[LINK_W-1:0] >= LINK_W'(PRELOAD)) && (v[LINK_W-1:0] < LINK_W'(DEPTH)))
      v[LINK_W-1:0] = LINK_W'(pick_index());
    if ((mode == MODE_SET || mode == MODE_RAW) && $urandom_range(0, 3) == 0)
      v[LINK_W-1:0] = LINK_W'(pick_index());
    h = HINT_W'($urandom());
    if (mode == MODE_LOAD)
      h = ($urandom_range(0, 3) == 0) ? HINT_W'($urandom_range(DEPTH, 8191))
                                      : HINT_W'($urandom_range(0, 127));
    send_req(mode, cl, v, 1'($urandom_range(0, 1)), h);
  endtask

  // receiver: random stall bursts, plus a long hold when asked
  initial begin : result_sink
    int hold_served;
    hold_served = 0;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_served < hold_asked) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served++;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL fat_cluster_chain_engine_top");
    $finish;
  end

  initial begin : stimulus
    int i;
    int p;
    int start;
    bit held;
    bit paused;
    logic [HINT_W-1:0] entries_set;
    logic [LINK_W-1:0] eoc_set;

    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_ENTRIES;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_GET;
    quiet      = 1'b1;
    hold_asked = 0;
    sent       = 0;
    held       = 1'b0;
    paused     = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // table contents are undefined out of reset: give the low entries a free link
    for (i = 0; i < PRELOAD; i++)
      send_req(MODE_RAW, LINK_W'(i), {4'($urandom()), 28'h0}, 1'($urandom_range(0, 1)),
               HINT_W'($urandom()));
    quiet = 1'b0;

    // corner requests under reset register values
    send_req(MODE_RAW,   LINK_W'(DEPTH - 1), 32'h0, 1'b0, '0);
    send_req(MODE_SET,   LINK_W'(DEPTH - 1), 32'hFFFF_FFFF, 1'b0, '0);
    send_req(MODE_GET,   LINK_W'(DEPTH - 1), '0, 1'b0, '0);
    send_req(MODE_GET,   28'h0FFF_FFFF, '0, 1'b0, '0);
    send_req(MODE_SET,   LINK_W'(DEPTH), 32'h1234_5678, 1'b0, '0);
    send_req(MODE_RAW,   28'h0FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 13'h1FFF);
    send_req(MODE_FREE,  28'h0FFF_FFFF, '0, 1'b0, '0);
    send_req(MODE_TRUNC, LINK_W'(DEPTH), '0, 1'b0, '0);
    send_req(MODE_COUNT, LINK_W'(DEPTH), '0, 1'b0, '0);
    send_req(MODE_ALLOC, 28'h0FFF_FFFF, '0, 1'b1, '0);
    send_req(MODE_LOAD,  '0, 32'h0, 1'b0, '0);
    // free count wraps below zero
    send_req(MODE_ALLOC, '0, '0, 1'b0, '0);
    send_req(MODE_ALLOC, '0, '0, 1'b1, '0);
    send_req(MODE_COUNT, '0, '0, 1'b0, '0);
    send_req(MODE_COUNT, 28'd1, '0, 1'b0, '0);
    send_req(MODE_FREE,  '0, '0, 1'b0, '0);
    // chain running into an out-of-range link
    send_req(MODE_SET,   28'd5, 32'd6, 1'b0, '0);
    send_req(MODE_SET,   28'd6, 32'd7, 1'b0, '0);
    send_req(MODE_SET,   28'd7, 32'h0000_5000, 1'b0, '0);
    send_req(MODE_COUNT, 28'd5, '0, 1'b0, '0);
    send_req(MODE_TRUNC, 28'd5, '0, 1'b0, '0);
    send_req(MODE_TRUNC, 28'd5, '0, 1'b0, '0);
    send_req(MODE_TRUNC, 28'd6, '0, 1'b0, '0);
    // two-entry loop
    send_req(MODE_SET,   28'd9, 32'd10, 1'b0, '0);
    send_req(MODE_SET,   28'd10, 32'd9, 1'b0, '0);
    send_req(MODE_COUNT, 28'd9, '0, 1'b0, '0);
    send_req(MODE_FREE,  28'd9, '0, 1'b0, '0);
    // hint past the scan limit, free count wraps past the top
    send_req(MODE_LOAD,  '0, 32'hFFFF_FFFF, 1'b0, 13'd4096);
    send_req(MODE_ALLOC, '0, '0, 1'b0, '0);
    send_req(MODE_FREE,  28'd1, '0, 1'b0, '0);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin entries_set = 13'd4096; eoc_set = 28'h0FFF_FFFF; end
        1: begin entries_set = 13'd0;    eoc_set = 28'h0FFF_FFF8; end
        2: begin
          entries_set = 13'd64;
          eoc_set     = END_FIRST + LINK_W'($urandom_range(0, 7));
        end
        3: begin entries_set = 13'd4095; eoc_set = 28'h0FFF_FFF8; end
        4: begin entries_set = 13'd1;    eoc_set = 28'h0FFF_FFFF; end
        default: begin
          entries_set = HINT_W'($urandom_range(0, DEPTH));
          eoc_set     = END_FIRST + LINK_W'($urandom_range(0, 7));
        end
      endcase
      quiet = (p == PHASES - 1);
      write_reg(CFG_ENTRIES, CFG_W'(entries_set));
      write_reg(CFG_END_MARKER, eoc_set);
      send_req(MODE_LOAD, LINK_W'($urandom()), $urandom(), 1'b0,
               HINT_W'($urandom_range(0, 63)));
      start = sent;
      while (sent - start < RANDOM_ITEMS / PHASES) begin
        if (p == 1 && !held && sent - start > 40) begin
          hold_asked++;
          held = 1'b1;
        end
        if (p == 2 && !paused && sent - start > RANDOM_ITEMS / (2 * PHASES)) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) run_chain_sequence();
        else send_noise_item();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("run covered %0d requests (table preload included) over %0d register settings",
             sent, PHASES);
    $display("%0d results checked, %0d of them with a non-ok status", checked, flagged);
    if (mismatches == 0 && pending == 0)
      $display("PASS fat_cluster_chain_engine_top");
    else
      $display("FAIL fat_cluster_chain_engine_top");
    $finish;
  end

endmodule

// ===== fat_cluster_chain_engine_top.f =====
rtl/core/fcc_pkg.sv
rtl/core/fcc_ram.sv
rtl/core/fat_cluster_chain_engine_top.sv
tb/fat_chain_checker.sv
tb/tb_top.sv
